### sv/rbd_pkg.sv
package rbd_pkg;

    localparam int unsigned RBD_MAX_WIDTH  = 4096;
    localparam int unsigned RBD_PIX_W      = 8;
    localparam int unsigned RBD_SUM_W      = RBD_PIX_W + 1;
    localparam int unsigned RBD_ENTRY_W    = 3 * RBD_SUM_W;
    localparam int unsigned RBD_ROW_W      = 16;
    localparam int unsigned RBD_CFG_IDX_W  = 8;
    localparam int unsigned RBD_CFG_DATA_W = 17;
    localparam int unsigned RBD_SRC_W_W    = 13;

    localparam logic [RBD_CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 8'd0;
    localparam logic [RBD_CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 8'd1;

    localparam logic [RBD_CFG_DATA_W-1:0] RBD_SRC_WIDTH_RST  = 17'd256;
    localparam logic [RBD_CFG_DATA_W-1:0] RBD_SRC_HEIGHT_RST = 17'd256;
    localparam logic [RBD_CFG_DATA_W-1:0] RBD_MAX_HEIGHT     = 17'd65536;

    localparam logic [RBD_PIX_W-1:0] RBD_OUT_ALPHA = 8'hFF;

    // pair sums of an odd-row pair, waiting for the line entry
    typedef struct packed {
        logic                 valid;
        logic [RBD_SUM_W-1:0] red;
        logic [RBD_SUM_W-1:0] green;
        logic [RBD_SUM_W-1:0] blue;
        logic                 last;
    } rbd_blk_req_t;

    // clamp, force even, floor at 2, then minus one
    function automatic logic [RBD_CFG_DATA_W-1:0] rbd_eff_last(
        input logic [RBD_CFG_DATA_W-1:0] src,
        input logic [RBD_CFG_DATA_W-1:0] lim
    );
        logic [RBD_CFG_DATA_W-1:0] v;
        v = (src > lim) ? lim : src;
        v[0] = 1'b0;
        if (v < 17'd2)
        begin
            v = 17'd2;
        end
        return v - 17'd1;
    endfunction

endpackage

### sv/rbd_if.sv
interface rbd_pix_in_if;
    import rbd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RBD_PIX_W-1:0] in_red;
    logic [RBD_PIX_W-1:0] in_green;
    logic [RBD_PIX_W-1:0] in_blue;
    logic [RBD_PIX_W-1:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rbd_pix_out_if;
    import rbd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RBD_PIX_W-1:0] out_red;
    logic [RBD_PIX_W-1:0] out_green;
    logic [RBD_PIX_W-1:0] out_blue;
    logic [RBD_PIX_W-1:0] out_alpha;
    logic                 frame_end;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                  output ready);
endinterface

interface rbd_cfg_if;
    import rbd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [RBD_CFG_IDX_W-1:0]  index;
    logic [RBD_CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/rgba_box_downsample_2x2.sv
// Channel   Dir  Beat payload
// pix_in    in   in_red, in_green, in_blue, in_alpha (one source pixel, raster order)
// pix_out   out  out_red, out_green, out_blue, out_alpha, frame_end (one 2x2 mean)
// cfg       in   index, data (0: source_width, 1: source_height)
//
// One pixel per clock sustained unless stalled; block sums pass the block stage,
// then the output register. The line store does one read or one write per pixel pair.
// Reset clears counters and restores 256x256; the line store is not cleared.
// pix_in stalls only when block stage and output are full and pix_out is not ready.
module rgba_box_downsample_2x2 #(
    parameter int unsigned MAX_WIDTH = rbd_pkg::RBD_MAX_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    rbd_pix_in_if.sink    pix_in,
    rbd_pix_out_if.source pix_out,
    rbd_cfg_if.sink       cfg
);
    import rbd_pkg::*;

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);

    rbd_blk_req_t           req;
    logic                   take_ok;
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      addr;
    logic [RBD_ENTRY_W-1:0] wr_data;
    logic [RBD_ENTRY_W-1:0] rd_data;

    rbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .cfg     (cfg),
        .take_ok (take_ok),
        .req     (req),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (addr),
        .wr_data (wr_data)
    );

    rbd_line_ram #(
        .DEPTH  (LINE_DEPTH),
        .DATA_W (RBD_ENTRY_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    rbd_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data),
        .pix_out (pix_out),
        .take_ok (take_ok)
    );

endmodule

### sv/rbd_line_ram.sv
module rbd_line_ram #(
    parameter int unsigned DEPTH  = rbd_pkg::RBD_MAX_WIDTH / 2,
    parameter int unsigned DATA_W = rbd_pkg::RBD_ENTRY_W,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/rbd_front.sv
module rbd_front #(
    parameter int unsigned MAX_WIDTH = rbd_pkg::RBD_MAX_WIDTH,
    localparam int unsigned ADDR_W = $clog2(MAX_WIDTH / 2)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rbd_pix_in_if.sink                pix_in,
    rbd_cfg_if.sink                   cfg,
    input  logic                      take_ok,
    output rbd_pkg::rbd_blk_req_t     req,
    output logic                      wr_en,
    output logic                      rd_en,
    output logic [ADDR_W-1:0]         addr,
    output logic [rbd_pkg::RBD_ENTRY_W-1:0] wr_data
);
    import rbd_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam logic [RBD_CFG_DATA_W-1:0] MAX_W = RBD_CFG_DATA_W'(MAX_WIDTH);
    localparam logic [RBD_CFG_DATA_W-1:0] W_LAST_RST = rbd_eff_last(RBD_SRC_WIDTH_RST, MAX_W);
    localparam logic [RBD_CFG_DATA_W-1:0] H_LAST_RST =
        rbd_eff_last(RBD_SRC_HEIGHT_RST, RBD_MAX_HEIGHT);

    logic [COL_W-1:0]         w_last_reg;
    logic [RBD_ROW_W-1:0]     h_last_reg;
    logic [COL_W-1:0]         col_reg;
    logic [RBD_ROW_W-1:0]     row_reg;
    logic [3*RBD_PIX_W-1:0]   held_reg;
    logic                     accept;
    logic                     col_end;
    logic                     row_end;
    logic [RBD_SUM_W-1:0]     sum_r;
    logic [RBD_SUM_W-1:0]     sum_g;
    logic [RBD_SUM_W-1:0]     sum_b;
    logic [RBD_CFG_DATA_W-1:0] src_w;

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = take_ok;
    assign accept       = pix_in.valid && take_ok;
    assign src_w        = {{(RBD_CFG_DATA_W - RBD_SRC_W_W){1'b0}}, cfg.data[RBD_SRC_W_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_W'(W_LAST_RST);
            h_last_reg <= RBD_ROW_W'(H_LAST_RST);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SOURCE_WIDTH:  w_last_reg <= COL_W'(rbd_eff_last(src_w, MAX_W));
                CFG_SOURCE_HEIGHT: h_last_reg <=
                                       RBD_ROW_W'(rbd_eff_last(cfg.data, RBD_MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    assign col_end = (col_reg >= w_last_reg);
    assign row_end = (row_reg >= h_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !col_reg[0])
        begin
            held_reg <= {pix_in.in_blue, pix_in.in_green, pix_in.in_red};
        end
    end

    assign sum_r = {1'b0, pix_in.in_red}   + {1'b0, held_reg[RBD_PIX_W-1:0]};
    assign sum_g = {1'b0, pix_in.in_green} + {1'b0, held_reg[2*RBD_PIX_W-1:RBD_PIX_W]};
    assign sum_b = {1'b0, pix_in.in_blue}  + {1'b0, held_reg[3*RBD_PIX_W-1:2*RBD_PIX_W]};

    // even row: store pair sums; odd row: fetch them back to close the block
    assign addr    = col_reg[ADDR_W:1];
    assign wr_data = {sum_b, sum_g, sum_r};
    assign wr_en   = accept && col_reg[0] && !row_reg[0];
    assign rd_en   = accept && col_reg[0] && row_reg[0];

    assign req.valid = rd_en;
    assign req.red   = sum_r;
    assign req.green = sum_g;
    assign req.blue  = sum_b;
    assign req.last  = col_end && row_end;

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("line store read and write in one cycle");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.last) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap after frame end");

endmodule

### sv/rbd_merge.sv
module rbd_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rbd_pkg::rbd_blk_req_t           req,
    input  logic [rbd_pkg::RBD_ENTRY_W-1:0] rd_data,
    rbd_pix_out_if.source                   pix_out,
    output logic                            take_ok
);
    import rbd_pkg::*;

    localparam int unsigned TOT_W = RBD_SUM_W + 1;

    logic                 s1_valid_reg;
    rbd_blk_req_t         s1_reg;
    logic                 s1_adv;
    logic                 out_valid_reg;
    logic [RBD_PIX_W-1:0] out_r_reg;
    logic [RBD_PIX_W-1:0] out_g_reg;
    logic [RBD_PIX_W-1:0] out_b_reg;
    logic                 out_last_reg;
    logic [TOT_W-1:0]     tot_r;
    logic [TOT_W-1:0]     tot_g;
    logic [TOT_W-1:0]     tot_b;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign take_ok = !s1_valid_reg || s1_adv;

    assign tot_r = {1'b0, s1_reg.red}   + {1'b0, rd_data[RBD_SUM_W-1:0]};
    assign tot_g = {1'b0, s1_reg.green} + {1'b0, rd_data[2*RBD_SUM_W-1:RBD_SUM_W]};
    assign tot_b = {1'b0, s1_reg.blue}  + {1'b0, rd_data[3*RBD_SUM_W-1:2*RBD_SUM_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s1_reg <= req;
        end
        if (s1_adv)
        begin
            out_r_reg    <= tot_r[TOT_W-1:2];
            out_g_reg    <= tot_g[TOT_W-1:2];
            out_b_reg    <= tot_b[TOT_W-1:2];
            out_last_reg <= s1_reg.last;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = out_r_reg;
    assign pix_out.out_green = out_g_reg;
    assign pix_out.out_blue  = out_b_reg;
    assign pix_out.out_alpha = RBD_OUT_ALPHA;
    assign pix_out.frame_end = out_last_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> take_ok)
        else $error("block request while stage one is full");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("stage one moved but output empty");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output beat without a pending block");

endmodule
